FILE: hw/rtl/scmc_pkg.sv
// Package for the shader container model check block.
// Payload structs, phase enum, status and fault codes, container constants.
// No dependencies.
package scmc_pkg;

  localparam int unsigned MAX_PARTS_DEF = 16;

  localparam logic [31:0] OUTER_MAGIC = 32'h4342_5844;
  localparam logic [31:0] PROG_MAGIC  = 32'h4c49_5844;
  localparam logic [31:0] SIZE_LIMIT  = 32'h8000_0000;

  localparam logic [1:0] FAULT_NONE        = 2'd0;
  localparam logic [1:0] FAULT_INVALID     = 2'd1;
  localparam logic [1:0] FAULT_UNSUPPORTED = 2'd2;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_INVALID     = 2'd1;
  localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;

  localparam logic [1:0] STAGE_PIXEL   = 2'd0;
  localparam logic [1:0] STAGE_VERTEX  = 2'd1;
  localparam logic [1:0] STAGE_COMPUTE = 2'd2;

  typedef enum logic [2:0] {
    PH_HDR,
    PH_TABLE,
    PH_PHDR,
    PH_PROG,
    PH_BODY,
    PH_DONE,
    PH_HALT
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] shader_model;
  } out_item_t;

endpackage

FILE: hw/rtl/scmc_ram.sv
// Generic single write port RAM with one registered read port.
// No dependencies.
module scmc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/shader_container_model_check.sv
// Shader container model check, top level.
// Parses the container byte stream and reports status and shader model.
// Depends on scmc_pkg and scmc_ram.
//
//  channel | direction | payload     | transfer when
//  in_     | in        | in_item_t   | in_valid && in_ready
//  out_    | out       | out_item_t  | out_valid && out_ready
//  cfg_    | in        | shader_stage| cfg_valid && cfg_ready
//
// One byte per cycle while in_ready is high; every byte is handled in the cycle it is accepted.
// The result of the last byte appears in the output register in the next cycle.
// in_ready drops only while a result waits and out_ready is low.
// Synchronous active-low reset clears all stream state and the stage register.
// The offset table is a RAM read one part ahead, so no bubble at part boundaries.
module shader_container_model_check
  import scmc_pkg::*;
#(
  parameter int unsigned MAX_PARTS = MAX_PARTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0] cfg_shader_stage
);

  localparam int unsigned AW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int unsigned IW = $clog2(MAX_PARTS + 1);

  logic [1:0]  stage_r;
  phase_t      phase_r, phase_nxt;
  logic [31:0] byte_pos_r, byte_pos_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [31:0] declared_r, declared_nxt;
  logic [31:0] parts_r, parts_nxt;
  logic [IW-1:0] pidx_r, pidx_nxt;
  logic [31:0] exp_r, exp_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] f0_r, f0_nxt, f1_r, f1_nxt, f2_r, f2_nxt, f4_r, f4_nxt;
  logic        seen_r, seen_nxt;
  logic [1:0]  fault_r, fault_nxt;
  logic [7:0]  model_r, model_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic          in_fire;
  logic [31:0]   ws, p, rel;
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  logic [31:0] tb_off;
  logic        tb_fail;
  logic [31:0] ep_len, ep_exp;
  logic [IW-1:0] ep_idx;
  logic        ep_done, ep_fail;
  logic [33:0] span, boff, bsize;
  logic        prog_bad;
  logic [15:0] kind;
  logic        stage_bad;
  logic [32:0] body_end;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign ws  = {in_data.data_byte, shift_r[31:8]};
  assign p   = byte_pos_r;
  assign rel = p - exp_r;

  // next part's offset is prefetched while the current part streams
  assign ram_raddr = (phase_r == PH_TABLE) ? '0 : AW'(pidx_r + IW'(1));
  assign ram_we    = in_fire && (phase_r == PH_TABLE) && (p[1:0] == 2'd3);

  scmc_ram #(
    .WIDTH(32),
    .DEPTH(MAX_PARTS)
  ) u_offset_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(pidx_r)),
    .wdata(ws),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign tb_off  = (parts_r == 32'd1) ? ws : ram_rdata;
  assign tb_fail = (tb_off != exp_r) || (tb_off > declared_r) || ((declared_r - tb_off) < 32'd8);

  assign ep_len  = (phase_r == PH_PHDR) ? ws : len_r;
  assign ep_exp  = exp_r + 32'd8 + ep_len;
  assign ep_idx  = pidx_r + IW'(1);
  assign ep_done = 32'(ep_idx) >= parts_r;
  assign ep_fail = (ram_rdata != ep_exp) || (ram_rdata > declared_r) ||
                   ((declared_r - ram_rdata) < 32'd8);

  assign span  = {f1_r, 2'b00} - 34'd8;
  assign boff  = {2'b00, f4_r};
  assign bsize = {2'b00, ws};
  assign prog_bad = (f1_r < 32'd6) || (f1_r > {2'b00, len_r[31:2]}) ||
                    (f2_r != PROG_MAGIC) || (boff < 34'd16) || (boff > span) ||
                    (ws == 32'd0) || (bsize > (span - boff));

  always_comb begin
    kind      = 16'd0;
    stage_bad = 1'b0;
    unique case (stage_r)
      STAGE_PIXEL:   kind = 16'd0;
      STAGE_VERTEX:  kind = 16'd1;
      STAGE_COMPUTE: kind = 16'd5;
      default:       stage_bad = 1'b1;
    endcase
  end

  assign body_end = {1'b0, exp_r} + 33'd8 + {1'b0, len_r};

  always_comb begin
    phase_nxt    = phase_r;
    byte_pos_nxt = byte_pos_r;
    shift_nxt    = shift_r;
    declared_nxt = declared_r;
    parts_nxt    = parts_r;
    pidx_nxt     = pidx_r;
    exp_nxt      = exp_r;
    len_nxt      = len_r;
    tag_nxt      = tag_r;
    f0_nxt       = f0_r;
    f1_nxt       = f1_r;
    f2_nxt       = f2_r;
    f4_nxt       = f4_r;
    seen_nxt     = seen_r;
    fault_nxt    = fault_r;
    model_nxt    = model_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    if (in_fire) begin
      shift_nxt    = ws;
      byte_pos_nxt = (byte_pos_r == 32'hffff_ffff) ? byte_pos_r : byte_pos_r + 32'd1;

      unique case (phase_r)
        PH_HDR: begin
          if ((p == 32'd3) && (ws != OUTER_MAGIC)) begin
            fault_nxt = FAULT_INVALID;
            phase_nxt = PH_HALT;
          end else if ((p == 32'd23) && (ws[15:0] != 16'd1)) begin
            fault_nxt = FAULT_INVALID;
            phase_nxt = PH_HALT;
          end else begin
            if (p == 32'd27) begin
              declared_nxt = ws;
            end
            if (p == 32'd31) begin
              parts_nxt = ws;
              if ((declared_r < 32'd32) || (declared_r > SIZE_LIMIT) ||
                  (ws > {2'b00, declared_r[31:2] - 30'd8}) || (ws > 32'(MAX_PARTS))) begin
                fault_nxt = FAULT_INVALID;
                phase_nxt = PH_HALT;
              end else begin
                exp_nxt   = 32'd32 + {ws[29:0], 2'b00};
                pidx_nxt  = '0;
                phase_nxt = (ws == 32'd0) ? PH_DONE : PH_TABLE;
              end
            end
          end
        end
        PH_TABLE: begin
          if (p[1:0] == 2'd3) begin
            if (32'(ep_idx) >= parts_r) begin
              pidx_nxt = '0;
              if (tb_fail) begin
                fault_nxt = FAULT_INVALID;
                phase_nxt = PH_HALT;
              end else begin
                phase_nxt = PH_PHDR;
              end
            end else begin
              pidx_nxt = ep_idx;
            end
          end
        end
        PH_PHDR: begin
          if (rel == 32'd3) begin
            tag_nxt = ws;
          end
          if (rel == 32'd7) begin
            len_nxt = ws;
            if (ws > (declared_r - exp_r - 32'd8)) begin
              fault_nxt = FAULT_INVALID;
              phase_nxt = PH_HALT;
            end else if (tag_r == PROG_MAGIC) begin
              seen_nxt = 1'b1;
              if (seen_r || (ws < 32'd24)) begin
                fault_nxt = FAULT_INVALID;
                phase_nxt = PH_HALT;
              end else begin
                phase_nxt = PH_PROG;
              end
            end else if (ws == 32'd0) begin
              exp_nxt  = ep_exp;
              pidx_nxt = ep_idx;
              if (ep_done) begin
                phase_nxt = PH_DONE;
              end else if (ep_fail) begin
                fault_nxt = FAULT_INVALID;
                phase_nxt = PH_HALT;
              end else begin
                phase_nxt = PH_PHDR;
              end
            end else begin
              phase_nxt = PH_BODY;
            end
          end
        end
        PH_PROG: begin
          if ((rel >= 32'd8) && (rel < 32'd32) && (rel[1:0] == 2'd3)) begin
            unique case (rel[4:2])
              3'd2:    f0_nxt = ws;
              3'd3:    f1_nxt = ws;
              3'd4:    f2_nxt = ws;
              3'd6:    f4_nxt = ws;
              default: ;
            endcase
          end
          if (rel == 32'd31) begin
            priority if (prog_bad || stage_bad || (f0_r[31:16] != kind) ||
                         (f0_r[15:8] != 8'd0) || (f0_r[7:4] < 4'd6)) begin
              fault_nxt = FAULT_INVALID;
              phase_nxt = PH_HALT;
            end else if (f0_r[7:4] != 4'd6) begin
              fault_nxt = FAULT_UNSUPPORTED;
              phase_nxt = PH_HALT;
            end else begin
              model_nxt = f0_r[7:0];
              if (len_r == 32'd24) begin
                exp_nxt  = ep_exp;
                pidx_nxt = ep_idx;
                if (ep_done) begin
                  phase_nxt = PH_DONE;
                end else if (ep_fail) begin
                  fault_nxt = FAULT_INVALID;
                  phase_nxt = PH_HALT;
                end else begin
                  phase_nxt = PH_PHDR;
                end
              end else begin
                phase_nxt = PH_BODY;
              end
            end
          end
        end
        PH_BODY: begin
          if (({1'b0, p} + 33'd1) == body_end) begin
            exp_nxt  = ep_exp;
            pidx_nxt = ep_idx;
            if (ep_done) begin
              phase_nxt = PH_DONE;
            end else if (ep_fail) begin
              fault_nxt = FAULT_INVALID;
              phase_nxt = PH_HALT;
            end else begin
              phase_nxt = PH_PHDR;
            end
          end
        end
        default: ;
      endcase

      if (in_data.last_byte) begin
        out_valid_nxt = 1'b1;
        out_data_nxt.shader_model = 8'd0;
        priority if ((byte_pos_nxt < 32'd32) || (fault_nxt == FAULT_INVALID) ||
                     (declared_nxt > byte_pos_nxt)) begin
          out_data_nxt.status = STATUS_INVALID;
        end else if (fault_nxt == FAULT_UNSUPPORTED) begin
          out_data_nxt.status = STATUS_UNSUPPORTED;
        end else if ((phase_nxt != PH_DONE) || (exp_nxt != declared_nxt)) begin
          out_data_nxt.status = STATUS_INVALID;
        end else begin
          out_data_nxt.status       = STATUS_OK;
          out_data_nxt.shader_model = model_nxt;
        end
        phase_nxt    = PH_HDR;
        byte_pos_nxt = '0;
        shift_nxt    = '0;
        declared_nxt = '0;
        parts_nxt    = '0;
        pidx_nxt     = '0;
        exp_nxt      = '0;
        len_nxt      = '0;
        tag_nxt      = '0;
        f0_nxt       = '0;
        f1_nxt       = '0;
        f2_nxt       = '0;
        f4_nxt       = '0;
        seen_nxt     = 1'b0;
        fault_nxt    = FAULT_NONE;
        model_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r     <= '0;
      phase_r     <= PH_HDR;
      byte_pos_r  <= '0;
      shift_r     <= '0;
      declared_r  <= '0;
      parts_r     <= '0;
      pidx_r      <= '0;
      exp_r       <= '0;
      len_r       <= '0;
      tag_r       <= '0;
      f0_r        <= '0;
      f1_r        <= '0;
      f2_r        <= '0;
      f4_r        <= '0;
      seen_r      <= 1'b0;
      fault_r     <= FAULT_NONE;
      model_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        stage_r <= cfg_shader_stage;
      end
      phase_r     <= phase_nxt;
      byte_pos_r  <= byte_pos_nxt;
      shift_r     <= shift_nxt;
      declared_r  <= declared_nxt;
      parts_r     <= parts_nxt;
      pidx_r      <= pidx_nxt;
      exp_r       <= exp_nxt;
      len_r       <= len_nxt;
      tag_r       <= tag_nxt;
      f0_r        <= f0_nxt;
      f1_r        <= f1_nxt;
      f2_r        <= f2_nxt;
      f4_r        <= f4_nxt;
      seen_r      <= seen_nxt;
      fault_r     <= fault_nxt;
      model_r     <= model_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  a_fault_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (fault_r != FAULT_NONE && !(in_fire && in_data.last_byte)) |=> (fault_r == $past(fault_r)))
    else $error("fault code changed before end of stream");

  a_halt_has_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HALT) |-> (fault_r != FAULT_NONE))
    else $error("halted without a fault");

  a_result_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.last_byte) |=> (out_valid_r && phase_r == PH_HDR && byte_pos_r == 32'd0))
    else $error("final byte did not produce a result");

  a_ok_needs_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == STATUS_OK) |-> (out_data_r.shader_model[7:4] == 4'd6 ||
    out_data_r.shader_model == 8'd0))
    else $error("accepted result with bad model");

endmodule
